/* design/bfsm_pkg.sv */
// Shared types and constants for the blocking flow shop makespan block.
package bfsm_pkg;

   // Field widths
   localparam int PT_W = 16;
   localparam int CT_W = 32;
   localparam int MC_W = 6;

   // Defaults
   localparam int MAX_MACHINES_DEF = 32;
   localparam logic [MC_W-1:0] MC_RESET = 6'd1;

   // Width of one stored machine entry: completion time and processing time
   localparam int ENT_W = CT_W + PT_W;

   typedef struct packed {
      logic [PT_W-1:0] proc_time;
      logic            new_sequence;
      logic            final_job;
   } req_type;

   typedef struct packed {
      logic [CT_W-1:0] completion_time;
      logic            is_makespan;
   } rsp_type;

endpackage

/* design/bfsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bfsm_ram #(
   parameter int WIDTH = bfsm_pkg::ENT_W,
   parameter int DEPTH = bfsm_pkg::MAX_MACHINES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/blocking_flowshop_makespan.sv */
// Blocking flow shop makespan: one operation per cycle, one result per job.
// A job's last operation leaves the input register, then its result is registered.
// Throughput: one operation per cycle; a job's last operation stalls only while the
// previous result is still held. Per-machine entries are fetched from RAM on accept.
// Reset (synchronous): clears sequence state and sets the machine count to 1;
// per-machine entries are tracked by valid bits, so there is no clearing pass.
module blocking_flowshop_makespan #(
   parameter int MAX_MACHINES = bfsm_pkg::MAX_MACHINES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bfsm_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bfsm_pkg::rsp_type         rsp_data,
   input  logic                      csr_wr_en,
   input  logic [bfsm_pkg::MC_W-1:0] csr_wr_data
);

   localparam int IDX_W  = $clog2(MAX_MACHINES);
   localparam int CW_RAW = $clog2(MAX_MACHINES + 1);
   localparam int CNT_W  = (CW_RAW > bfsm_pkg::MC_W) ? CW_RAW : bfsm_pkg::MC_W;
   localparam int CT_W   = bfsm_pkg::CT_W;
   localparam int PT_W   = bfsm_pkg::PT_W;
   localparam int ENT_W  = bfsm_pkg::ENT_W;

   // Clamp the machine count into 1..MAX_MACHINES
   function automatic logic [CNT_W-1:0] clamp_count(input logic [bfsm_pkg::MC_W-1:0] v);
      logic [CNT_W-1:0] ext;
      ext = CNT_W'(v);
      if (v == '0) begin
         return CNT_W'(1);
      end else if (ext > CNT_W'(MAX_MACHINES)) begin
         return CNT_W'(MAX_MACHINES);
      end else begin
         return ext;
      end
   endfunction

   // Configuration
   logic [bfsm_pkg::MC_W-1:0] mc_ff, mc_in;
   logic [CNT_W-1:0]          m_cur, m_nxt;

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   bfsm_pkg::req_type s1_data_ff;

   // Sequence state
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CT_W-1:0]         left_ff, left_in;
   logic                    first_ff, first_in;
   logic [MAX_MACHINES-1:0] valid_ff, valid_in;

   // Fetched entry and forwarding
   logic             byp_hit_ff;
   logic [ENT_W-1:0] byp_data_ff;
   logic             ent_valid_ff;
   logic [ENT_W-1:0] ram_rd_data;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   bfsm_pkg::rsp_type rsp_data_ff;

   // Datapath
   logic             req_fire, s1_fire;
   logic             newseq, is_last, first_cur;
   logic [IDX_W-1:0] j;
   logic [CNT_W-1:0] j_plus;
   logic [CT_W-1:0]  left_cur, nd, start_next, other, cand, base, t;
   logic [PT_W-1:0]  np;
   logic [ENT_W-1:0] ent;
   logic [CT_W:0]    sum_wide;
   logic [ENT_W-1:0] wr_data;

   // Prefetch
   logic [IDX_W-1:0] pre_j, rd_addr;
   logic [CNT_W-1:0] pre_plus;

   assign mc_in = csr_wr_en ? csr_wr_data : mc_ff;
   assign m_cur = clamp_count(mc_ff);
   assign m_nxt = clamp_count(mc_in);

   // Handshakes
   assign req_fire  = req_valid && req_ready;
   assign s1_fire   = s1_valid_ff && (!is_last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   // Current operation: machine index, left neighbour, first-job flag
   always_comb begin
      newseq = s1_data_ff.new_sequence;
      if (newseq || (CNT_W'(idx_ff) >= m_cur)) begin
         j = '0;
      end else begin
         j = idx_ff;
      end
      j_plus    = CNT_W'(j) + CNT_W'(1);
      is_last   = (j_plus == m_cur);
      left_cur  = (j == '0) ? '0 : left_ff;
      first_cur = newseq || first_ff;
   end

   // Completion time: first job left, else max(left, blocking term), + processing time
   always_comb begin
      ent = byp_hit_ff ? byp_data_ff : ram_rd_data;
      nd  = ent_valid_ff ? ent[ENT_W-1:PT_W] : '0;
      np  = ent_valid_ff ? ent[PT_W-1:0] : '0;
      start_next = (nd > CT_W'(np)) ? (nd - CT_W'(np)) : '0;
      other      = is_last ? nd : start_next;
      cand       = (left_cur > other) ? left_cur : other;
      base       = first_cur ? left_cur : cand;
      sum_wide   = {1'b0, base} + (CT_W + 1)'(s1_data_ff.proc_time);
      t          = sum_wide[CT_W] ? '1 : sum_wide[CT_W-1:0];
      wr_data    = {t, s1_data_ff.proc_time};
   end

   // Next sequence state
   always_comb begin
      idx_in   = idx_ff;
      left_in  = left_ff;
      first_in = first_ff;
      valid_in = valid_ff;
      if (s1_fire) begin
         idx_in   = is_last ? '0 : j_plus[IDX_W-1:0];
         left_in  = is_last ? '0 : t;
         first_in = is_last ? 1'b0 : first_cur;
         valid_in = (newseq ? '0 : valid_ff) | (MAX_MACHINES'(1) << j);
      end
   end

   // Entry address for the next operation
   always_comb begin
      pre_j    = (CNT_W'(idx_in) >= m_nxt) ? '0 : idx_in;
      pre_plus = CNT_W'(pre_j) + CNT_W'(1);
      rd_addr  = (pre_plus < m_nxt) ? pre_plus[IDX_W-1:0] : pre_j;
   end

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_fire && is_last) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mc_ff        <= bfsm_pkg::MC_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         left_ff      <= '0;
         first_ff     <= 1'b1;
         valid_ff     <= '0;
      end else begin
         mc_ff        <= mc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         left_ff      <= left_in;
         first_ff     <= first_in;
         valid_ff     <= valid_in;
      end
   end

   // Capture the transaction and its fetched entry's validity and forwarding
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff   <= req_data;
         byp_hit_ff   <= s1_fire && (j == rd_addr);
         byp_data_ff  <= wr_data;
         ent_valid_ff <= valid_in[rd_addr];
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (s1_fire && is_last) begin
         rsp_data_ff.completion_time <= t;
         rsp_data_ff.is_makespan     <= s1_data_ff.final_job;
      end
   end

   bfsm_ram #(
      .WIDTH(ENT_W),
      .DEPTH(MAX_MACHINES)
   ) u_entries (
      .clock  (clock),
      .wr_en  (s1_fire),
      .wr_addr(j),
      .wr_data(wr_data),
      .rd_en  (req_fire),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/blocking_flowshop_makespan_tb.sv */
// Testbench for the blocking flow shop makespan block: queued stimulus, schedule predictor, checker.
`timescale 1ns / 1ps

module blocking_flowshop_makespan_tb;
   import bfsm_pkg::*;

   localparam int SHOP_MAX      = MAX_MACHINES_DEF;
   localparam int CYCLE_LIMIT   = 100_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int N_PHASES      = 14;
   localparam int PHASE_BUDGET  = 32;

   // Idling modes
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [MC_W-1:0]  csr_wr_data = '0;

   // Stimulus and expectation stores
   req_type          op_queue[$];
   rsp_type          completions_q[$];
   int               send_gap_pct  = 0;
   int               rsp_stall_pct = 0;
   int               mismatch_count = 0;
   int unsigned      cycle_count = 0;

   // Shadow of the shop schedule
   logic [MC_W-1:0]  shop_machines = MC_RESET;
   logic [CT_W-1:0]  finish_at [SHOP_MAX];
   logic [PT_W-1:0]  last_dur  [SHOP_MAX];
   int unsigned      next_machine  = 0;
   logic [CT_W-1:0]  upstream_done = '0;
   logic             opening_job   = 1'b1;

   blocking_flowshop_makespan u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("blocking_flowshop_makespan_tb: done, errors");
         $finish;
      end
   end

   function automatic int unsigned clamp_machines(input logic [MC_W-1:0] mc);
      if (mc == 0) return 1;
      if (mc > SHOP_MAX) return SHOP_MAX;
      return 32'(mc);
   endfunction

   // Wipe the sequence state on a new sequence
   task automatic clear_schedule();
      for (int i = 0; i < SHOP_MAX; i++) begin
         finish_at[i] = '0;
         last_dur[i]  = '0;
      end
      next_machine  = 0;
      upstream_done = '0;
      opening_job   = 1'b1;
   endtask

   // Advance the schedule by one operation; queue the job's completion when it ends
   task automatic advance_schedule(input req_type op);
      int unsigned     eff;
      int unsigned     j;
      logic [CT_W-1:0] left, base, nd, np, start_next;
      logic [CT_W:0]   sum;
      rsp_type         done_rec;
      eff = clamp_machines(shop_machines);
      if (op.new_sequence) clear_schedule();
      // count lowered under a half-done job: restart at machine 0
      if (next_machine >= eff) begin
         next_machine  = 0;
         upstream_done = '0;
      end
      j    = next_machine;
      left = (j == 0) ? '0 : upstream_done;
      if (opening_job) begin
         base = left;
      end else if (j + 1 < eff) begin
         // wait for the previous job to leave the next machine
         nd = finish_at[j + 1];
         np = {{(CT_W-PT_W){1'b0}}, last_dur[j + 1]};
         start_next = (nd > np) ? nd - np : '0;
         base = (left > start_next) ? left : start_next;
      end else begin
         base = (left > finish_at[j]) ? left : finish_at[j];
      end
      sum = {1'b0, base} + {{(CT_W+1-PT_W){1'b0}}, op.proc_time};
      finish_at[j]  = sum[CT_W] ? {CT_W{1'b1}} : sum[CT_W-1:0];
      last_dur[j]   = op.proc_time;
      upstream_done = finish_at[j];
      next_machine  = j + 1;
      if (next_machine >= eff) begin
         next_machine  = 0;
         upstream_done = '0;
         opening_job   = 1'b0;
         done_rec.completion_time = finish_at[j];
         done_rec.is_makespan     = op.final_job;
         completions_q.insert(completions_q.size(), done_rec);
      end
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: expected %h/%b, got %h/%b at %0t", what, want.completion_time,
                  want.is_makespan, got.completion_time, got.is_makespan, $realtime);
   endtask

   // Drive the next pending transaction, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (op_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_data  <= op_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Track register writes, predict accepted operations, check results
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (csr_wr_en) shop_machines = csr_wr_data;
         if (req_valid && req_ready) advance_schedule(req_data);
         if (rsp_valid && rsp_ready) begin
            if (completions_q.size() == 0) begin
               note_mismatch("completion with none pending", '0, rsp_data);
            end else begin
               want = completions_q.pop_front();
               if (rsp_data.completion_time !== want.completion_time ||
                   rsp_data.is_makespan !== want.is_makespan)
                  note_mismatch("completion mismatch", want, rsp_data);
            end
         end
      end
   end

   task automatic set_idling(input int mode);
      case (mode)
         IDLE_SEND: begin send_gap_pct = 57; rsp_stall_pct = 0;  end
         IDLE_RECV: begin send_gap_pct = 0;  rsp_stall_pct = 57; end
         IDLE_BOTH: begin send_gap_pct = 38; rsp_stall_pct = 38; end
         default:   begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
      endcase
   endtask

   task automatic queue_op(input logic [PT_W-1:0] pt, input logic ns, input logic fj);
      req_type op;
      op.proc_time    = pt;
      op.new_sequence = ns;
      op.final_job    = fj;
      op_queue.insert(op_queue.size(), op);
   endtask

   // Wait until every transaction is taken and every completion has arrived, then settle
   task automatic drain();
      while (op_queue.size() != 0 || req_valid) @(negedge clock);
      while (completions_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_machine_count(input logic [MC_W-1:0] mc);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mc;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [PT_W-1:0] pick_duration();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2, 3:    return PT_W'($urandom_range(15));
         default: return PT_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic logic [MC_W-1:0] phase_machines(input int ph);
      case (ph)
         0:  return 6'd2;
         1:  return 6'd3;
         2:  return 6'd32;
         3:  return 6'd1;
         4:  return 6'd4;
         5:  return 6'd63;
         6:  return 6'd5;
         7:  return 6'd0;
         8:  return 6'd7;
         9:  return 6'd33;
         10: return 6'd2;
         11: return 6'd6;
         12: return 6'd31;
         default: return 6'd3;
      endcase
   endfunction

   // Queue job sequences: mostly well formed, some with flipped flags or cut jobs
   task automatic queue_sequences(input int unsigned budget, input int unsigned eff);
      int unsigned produced, jobs, cut;
      bit          noisy, carry_on;
      logic        ns, fj;
      produced = 0;
      while (produced < budget) begin
         jobs = (budget - produced) / eff;
         if (jobs < 1) jobs = 1;
         if (jobs > 6) jobs = 6;
         jobs     = $urandom_range(1, jobs);
         noisy    = ($urandom_range(9) == 0);
         carry_on = ($urandom_range(4) == 0);
         for (int jb = 0; jb < jobs; jb++) begin
            cut = (noisy && $urandom_range(1) == 1) ? $urandom_range(eff - 1) : eff;
            for (int k = 0; k < cut; k++) begin
               ns = (jb == 0 && k == 0 && !carry_on);
               fj = (jb == jobs - 1);
               if (noisy) begin
                  if ($urandom_range(7) == 0) ns = ~ns;
                  if ($urandom_range(3) == 0) fj = ~fj;
               end
               queue_op(pick_duration(), ns, fj);
               produced++;
            end
         end
      end
   endtask

   initial begin
      int unsigned eff;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset count of one, chained completions, jobs after the final one
      set_idling(IDLE_NONE);
      queue_op(16'h0000, 1'b1, 1'b0);
      queue_op(16'hFFFF, 1'b0, 1'b0);
      queue_op(16'hFFFF, 1'b0, 1'b1);
      queue_op(16'h1234, 1'b0, 1'b0);
      drain();

      // Three machines: first job, middle and last machine rules, then a half-done job
      write_machine_count(6'd3);
      queue_op(16'hFFFF, 1'b1, 1'b0);
      queue_op(16'h0000, 1'b0, 1'b0);
      queue_op(16'h0005, 1'b0, 1'b0);
      queue_op(16'h0007, 1'b0, 1'b1);
      queue_op(16'hFFFF, 1'b0, 1'b1);
      queue_op(16'h0001, 1'b0, 1'b1);
      queue_op(16'h0003, 1'b0, 1'b0);
      queue_op(16'h0009, 1'b0, 1'b0);
      drain();

      // Lower the count under the unfinished job: it is dropped
      write_machine_count(6'd2);
      queue_op(16'h0004, 1'b0, 1'b0);
      queue_op(16'h0006, 1'b0, 1'b1);
      drain();

      // Count of zero acts as one; new sequence clears the history
      write_machine_count(6'd0);
      queue_op(16'h0008, 1'b0, 1'b0);
      queue_op(16'h0000, 1'b1, 1'b1);
      drain();

      // Random phases over counts and idling modes
      for (int ph = 0; ph < N_PHASES; ph++) begin
         set_idling(ph % 4);
         write_machine_count(phase_machines(ph));
         eff = clamp_machines(phase_machines(ph));
         queue_sequences(PHASE_BUDGET / 2, eff);
         // hold back the rest until every completion is in
         if (ph % 3 == 0) drain();
         queue_sequences(PHASE_BUDGET - PHASE_BUDGET / 2, eff);
         // leave a job unfinished for the next count
         if (eff > 1 && $urandom_range(1) == 1)
            repeat ($urandom_range(1, eff - 1)) queue_op(pick_duration(), 1'b0, 1'b0);
         drain();
      end

      if (mismatch_count == 0 && completions_q.size() == 0) begin
         $display("blocking_flowshop_makespan_tb: done, clean");
      end else begin
         $display("blocking_flowshop_makespan_tb: done, errors");
      end
      $finish;
   end

endmodule
